/* design/stks_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_pkg
// shared types and constants of the sorted table key range search block
// ----------------------------------------------------------------------------
package stks_pkg;

  localparam int unsigned VAL_W = 32;  // table entry and key width
  localparam int unsigned CNT_W = 11;  // entry count register width
  localparam int unsigned EIX_W = 10;  // entry index field width
  localparam int unsigned OUT_W = 11;  // result index width

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // write the item into the table
    logic init;    // latch key, open both search windows
    logic probe;   // read both midpoints
    logic update;  // compare and narrow both windows
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic any_active;  // at least one search window still open
  } status_t;

endpackage

/* design/stks_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_ctrl
// sequencer for loads and for the probe / compare loop of a query
// ----------------------------------------------------------------------------
module stks_ctrl
  import stks_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    kind_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy,
  output logic    result_strobe_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.load   = accept && (kind_i == KIND_LOAD);
    cmd_o.init   = accept && (kind_i == KIND_QUERY);
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.init) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (status_i.any_active) begin
          cmd_o.probe = 1'b1;
          state_d     = ST_CMP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        cmd_o.update = 1'b1;
        state_d      = ST_PROBE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign result_strobe_o = (state_q == ST_DONE);

  a_query_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.init |=> busy)
    else $error("query accepted but block not busy");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !busy && !result_strobe_o)
    else $error("load item led to busy or result");

  a_probe_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.probe |-> status_i.any_active)
    else $error("probe issued with both windows closed");

  a_cmp_after_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> $past(cmd_o.probe))
    else $error("compare without preceding probe");

endmodule

/* design/stks_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_datapath
// table memory, count register and two bisection windows searched in lockstep
// ----------------------------------------------------------------------------
module stks_datapath
  import stks_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic                    cfg_we_i,
  input  logic [CNT_W-1:0]        cfg_wdata_i,
  input  logic [EIX_W-1:0]        entry_index_i,
  input  logic signed [VAL_W-1:0] item_value_i,
  output logic signed [OUT_W-1:0] first_index_o,
  output logic signed [OUT_W-1:0] last_index_o,
  output logic                    found_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned POS_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NSRCH = 2;  // search 0 goes left on a match, search 1 right

  logic [VAL_W-1:0] mem [TABLE_DEPTH];

  logic [CNT_W-1:0]        count_q;
  logic signed [VAL_W-1:0] key_q;
  logic [POS_W-1:0]        lo_q    [NSRCH];
  logic [POS_W-1:0]        end_q   [NSRCH];  // exclusive upper bound
  logic [IDX_W-1:0]        mid_q   [NSRCH];
  logic [IDX_W-1:0]        mid_d   [NSRCH];
  logic [IDX_W-1:0]        hit_q   [NSRCH];
  logic                    hit_vld_q [NSRCH];
  logic [VAL_W-1:0]        rd_q    [NSRCH];
  logic [NSRCH-1:0]        active;

  logic [31:0]      count_ext;
  logic [POS_W-1:0] count_sat;
  logic [31:0]      widx_ext;
  logic             widx_ok;

  assign count_ext = 32'(count_q);
  assign count_sat = (count_ext > 32'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                    : count_ext[POS_W-1:0];
  assign widx_ext  = 32'(entry_index_i);
  assign widx_ok   = (widx_ext < 32'(TABLE_DEPTH));

  always_comb begin
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] mid_w;
    for (int s = 0; s < NSRCH; s++) begin
      active[s] = (lo_q[s] < end_q[s]);
      span      = end_q[s] - lo_q[s] - POS_W'(1);
      mid_w     = lo_q[s] + (span >> 1);
      mid_d[s]  = mid_w[IDX_W-1:0];
    end
  end

  assign status_o.any_active = |active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // table memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && widx_ok) begin
      mem[widx_ext[IDX_W-1:0]] <= item_value_i;
    end
    if (cmd_i.probe) begin
      for (int s = 0; s < NSRCH; s++) begin
        rd_q[s]  <= mem[mid_d[s]];
        mid_q[s] <= mid_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      key_q <= item_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSRCH; s++) begin
        lo_q[s]      <= '0;
        end_q[s]     <= '0;
        hit_q[s]     <= '0;
        hit_vld_q[s] <= 1'b0;
      end
    end else if (cmd_i.init) begin
      for (int s = 0; s < NSRCH; s++) begin
        lo_q[s]      <= '0;
        end_q[s]     <= count_sat;
        hit_vld_q[s] <= 1'b0;
      end
    end else if (cmd_i.update) begin
      for (int s = 0; s < NSRCH; s++) begin
        if (active[s]) begin
          priority if ($signed(rd_q[s]) == key_q) begin
            hit_q[s]     <= mid_q[s];
            hit_vld_q[s] <= 1'b1;
            if (s == 0) begin
              end_q[s] <= POS_W'(mid_q[s]);
            end else begin
              lo_q[s] <= POS_W'(mid_q[s]) + POS_W'(1);
            end
          end else if (key_q > $signed(rd_q[s])) begin
            lo_q[s] <= POS_W'(mid_q[s]) + POS_W'(1);
          end else begin
            end_q[s] <= POS_W'(mid_q[s]);
          end
        end
      end
    end
  end

  logic [OUT_W+IDX_W-1:0] first_w, last_w;

  assign first_w = {{OUT_W{1'b0}}, hit_q[0]};
  assign last_w  = {{OUT_W{1'b0}}, hit_q[1]};

  // absent key reads as all ones
  assign first_index_o = hit_vld_q[0] ? $signed(first_w[OUT_W-1:0]) : '1;
  assign last_index_o  = hit_vld_q[1] ? $signed(last_w[OUT_W-1:0])  : '1;
  assign found_o       = hit_vld_q[0];

  a_left_window_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q[0] <= end_q[0])
    else $error("left search window inverted");

  a_right_window_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q[1] <= end_q[1])
    else $error("right search window inverted");

endmodule

/* design/sorted_table_key_range_search_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_key_range_search_core
// lower and upper bound search of a key in a table of signed 32-bit entries
// ----------------------------------------------------------------------------
// Raise start while busy is low to hand over one item. A load (kind 0) writes
// item_value_i at entry_index_i and gives no result; indices at or beyond
// TABLE_DEPTH are dropped. A query (kind 1) bisects entries 0 to
// count-1 twice in lockstep, once for the first and once for the last index
// of the key, and presents first_index_o, last_index_o and found_o with
// result_strobe_o high for exactly one cycle; take them then, they are held
// only until the next query is accepted. A query keeps busy high from its
// acceptance through the result strobe; each search takes at most
// floor(log2(count))+1 probes, each a probe and a compare step of the loop
// around the registered read ports of the table memory. Write the count through
// cfg_we_i / cfg_wdata_i only while idle; values above TABLE_DEPTH saturate.
// ----------------------------------------------------------------------------
module sorted_table_key_range_search_core
  import stks_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind_i,
  input  logic [EIX_W-1:0]        entry_index_i,
  input  logic signed [VAL_W-1:0] item_value_i,
  input  logic                    cfg_we_i,
  input  logic [CNT_W-1:0]        cfg_wdata_i,
  output logic                    result_strobe_o,
  output logic signed [OUT_W-1:0] first_index_o,
  output logic signed [OUT_W-1:0] last_index_o,
  output logic                    found_o
);

  cmd_t    cmd;
  status_t status;

  stks_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .kind_i          (kind_i),
    .status_i        (status),
    .cmd_o           (cmd),
    .busy            (busy),
    .result_strobe_o (result_strobe_o)
  );

  stks_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_index_i (entry_index_i),
    .item_value_i  (item_value_i),
    .first_index_o (first_index_o),
    .last_index_o  (last_index_o),
    .found_o       (found_o)
  );

endmodule
